### rtl/core/tfn_pkg.sv
// Package for the triangle face normal unit: widths, stage beat types and
// the shift-and-subtract step of the normalizing square root search.
// No dependencies.
package tfn_pkg;

    localparam int COORD_BITS  = 24;
    localparam int NORMAL_BITS = 16;

    localparam int EW    = COORD_BITS + 1;          // edge width, signed
    localparam int PW    = 2 * EW;                  // edge product, signed
    localparam int CW    = PW + 1;                  // cross difference, signed
    localparam int MW    = 2 * COORD_BITS + 2;      // cross magnitude
    localparam int HW    = MW / 2;                  // half of magnitude
    localparam int SQW   = 2 * MW;                  // magnitude squared
    localparam int SW    = SQW + 2;                 // sum of three squares
    localparam int RW    = SW + 2 * NORMAL_BITS + 4;
    localparam int STEPS = NORMAL_BITS;

    localparam logic [NORMAL_BITS-1:0] FULL_VAL = NORMAL_BITS'(1) << (NORMAL_BITS - 1);
    localparam logic [NORMAL_BITS-1:0] MAX_VAL  = FULL_VAL - NORMAL_BITS'(1);

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [RW-1:0]         wide_t;

    // partial squares of the three cross components
    typedef struct packed {
        logic [2:0]          neg;
        logic [2:0][SQW-1:0] hh;
        logic [2:0][SQW-1:0] hl;
        logic [2:0][SQW-1:0] ll;
    } sq_beat_t;

    typedef struct packed {
        wide_t rem;
        wide_t acc;
        logic  take;
    } step_t;

    // rem = T - t*t*s, acc = t*s with t = 2q-1; try setting bit b of q
    function automatic step_t root_step(wide_t rem, wide_t acc, wide_t sum, int b);
        step_t r;
        wide_t trial;
        trial  = rem - (acc <<< (b + 2)) - (sum <<< (2 * b + 2));
        r.take = ~trial[RW-1];
        r.rem  = r.take ? trial : rem;
        r.acc  = r.take ? acc + (sum <<< (b + 1)) : acc;
        return r;
    endfunction

endpackage

### rtl/core/tfn_cross.sv
// Edge vectors, exact cross product and partial squares, four stages.
// Depends on tfn_pkg.
module tfn_cross import tfn_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     en,
    input  logic     in_valid,
    input  coord_t   ax, ay, az, bx, by, bz, cx, cy, cz,
    output logic     out_valid,
    output sq_beat_t out_beat
);

    logic [3:0] v_reg;
    logic signed [EW-1:0] e_reg [3];
    logic signed [EW-1:0] f_reg [3];
    logic signed [PW-1:0] p_reg [3];
    logic signed [PW-1:0] q_reg [3];
    logic [MW-1:0] mag_reg [3];
    logic [2:0] neg_reg;
    sq_beat_t sq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_reg[0] <= EW'(bx) - EW'(ax);
            e_reg[1] <= EW'(by) - EW'(ay);
            e_reg[2] <= EW'(bz) - EW'(az);
            f_reg[0] <= EW'(cx) - EW'(ax);
            f_reg[1] <= EW'(cy) - EW'(ay);
            f_reg[2] <= EW'(cz) - EW'(az);
        end
    end

    logic signed [CW-1:0] n_next [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_next[i] = CW'(p_reg[i]) - CW'(q_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                p_reg[i]   <= PW'(e_reg[(i + 1) % 3] * f_reg[(i + 2) % 3]);
                q_reg[i]   <= PW'(e_reg[(i + 2) % 3] * f_reg[(i + 1) % 3]);
                neg_reg[i] <= n_next[i][CW-1];
                mag_reg[i] <= n_next[i][CW-1] ? MW'(-n_next[i]) : MW'(n_next[i]);
                sq_reg.hh[i] <= SQW'(mag_reg[i][MW-1:HW] * mag_reg[i][MW-1:HW]);
                sq_reg.hl[i] <= SQW'(mag_reg[i][MW-1:HW] * mag_reg[i][HW-1:0]);
                sq_reg.ll[i] <= SQW'(mag_reg[i][HW-1:0] * mag_reg[i][HW-1:0]);
            end
            sq_reg.neg <= neg_reg;
        end
    end

    assign out_valid = v_reg[3];
    assign out_beat  = sq_reg;

endmodule

### rtl/core/tfn_root.sv
// Length sum, then one stage per result bit of the rounded component
// search, then the output register. Depends on tfn_pkg.
module tfn_root import tfn_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  sq_beat_t                      in_beat,
    output logic                          out_valid,
    output logic signed [NORMAL_BITS-1:0] nx,
    output logic signed [NORMAL_BITS-1:0] ny,
    output logic signed [NORMAL_BITS-1:0] nz,
    output logic                          degen
);

    logic [1:0] hv_reg;
    logic [2:0] hneg_reg [2];
    logic [SQW-1:0] n2_reg [3];
    logic [SW-1:0]  s_reg;
    logic [SQW-1:0] n2b_reg [3];

    logic [STEPS:0] v_reg;
    wide_t rem_reg [STEPS+1][3];
    wide_t acc_reg [STEPS+1][3];
    wide_t sum_reg [STEPS+1];
    logic [NORMAL_BITS-1:0] qv_reg [STEPS+1][3];
    logic [2:0] neg_reg [STEPS+1];
    logic deg_reg [STEPS+1];

    logic out_valid_reg, degen_reg;
    logic signed [NORMAL_BITS-1:0] n_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hv_reg        <= '0;
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            hv_reg        <= {hv_reg[0], in_valid};
            v_reg         <= {v_reg[STEPS-1:0], hv_reg[1]};
            out_valid_reg <= v_reg[STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                n2_reg[i] <= (in_beat.hh[i] << MW) + (in_beat.hl[i] << (HW + 1))
                             + in_beat.ll[i];
                n2b_reg[i] <= n2_reg[i];
            end
            hneg_reg[0] <= in_beat.neg;
            hneg_reg[1] <= hneg_reg[0];
            s_reg <= SW'(n2_reg[0]) + SW'(n2_reg[1]) + SW'(n2_reg[2]);
            for (int i = 0; i < 3; i++) begin
                rem_reg[0][i] <= (wide_t'(n2b_reg[i]) <<< (2 * NORMAL_BITS))
                                 - wide_t'(s_reg);
                acc_reg[0][i] <= -wide_t'(s_reg);
                qv_reg[0][i]  <= '0;
            end
            sum_reg[0] <= wide_t'(s_reg);
            neg_reg[0] <= hneg_reg[1];
            deg_reg[0] <= (s_reg == '0);
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam int B = STEPS - 1 - k;
        step_t st [3];
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                st[i] = root_step(rem_reg[k][i], acc_reg[k][i], sum_reg[k], B);
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    rem_reg[k+1][i] <= st[i].rem;
                    acc_reg[k+1][i] <= st[i].acc;
                    qv_reg[k+1][i]  <= qv_reg[k][i] | (NORMAL_BITS'(st[i].take) << B);
                end
                sum_reg[k+1] <= sum_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                deg_reg[k+1] <= deg_reg[k];
            end
        end
    end

    logic [NORMAL_BITS-1:0] sat [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sat[i] = qv_reg[STEPS][i][NORMAL_BITS-1] ? MAX_VAL : qv_reg[STEPS][i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            degen_reg <= deg_reg[STEPS];
            for (int i = 0; i < 3; i++) begin
                if (deg_reg[STEPS]) begin
                    n_reg[i] <= (i == 1) ? MAX_VAL : '0;
                end else begin
                    n_reg[i] <= neg_reg[STEPS][i] ? -sat[i] : sat[i];
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign nx    = n_reg[0];
    assign ny    = n_reg[1];
    assign nz    = n_reg[2];
    assign degen = degen_reg;

endmodule

### rtl/core/triangle_face_normal_unit.sv
// Triangle face normal unit: top level joining the cross product stages
// and the normalizing pipeline. Depends on tfn_pkg, tfn_cross, tfn_root.
//
// Usage:
//   Input channel s_*: one beat is one triangle, vertices A, B, C as
//   signed 24-bit coordinates. Output channel m_*: one beat per triangle,
//   the unit normal as Q1.15 components plus a degenerate flag (zero
//   cross product gives 0, 32767, 0 with degenerate high).
//   Pipeline: 4 cross product stages, 3 length stages, 16 search stages
//   (one per result bit, one wide subtract and compare each), then
//   1 output register.
//   Throughput: one triangle per cycle while the output is not stalled.
//   Stall: the whole pipeline holds while m_valid is high and m_ready low;
//   s_ready is low then. Bubbles advance freely when the output is empty.
//   Reset: aresetn low clears all stage valid bits; no beats are in flight
//   afterwards.
module triangle_face_normal_unit import tfn_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  coord_t                        s_vertex_a_x,
    input  coord_t                        s_vertex_a_y,
    input  coord_t                        s_vertex_a_z,
    input  coord_t                        s_vertex_b_x,
    input  coord_t                        s_vertex_b_y,
    input  coord_t                        s_vertex_b_z,
    input  coord_t                        s_vertex_c_x,
    input  coord_t                        s_vertex_c_y,
    input  coord_t                        s_vertex_c_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [NORMAL_BITS-1:0] m_normal_x,
    output logic signed [NORMAL_BITS-1:0] m_normal_y,
    output logic signed [NORMAL_BITS-1:0] m_normal_z,
    output logic                          m_degenerate
);

    logic     en;
    logic     sq_valid;
    sq_beat_t sq_beat;

    assign en      = ~m_valid | m_ready;
    assign s_ready = en;

    tfn_cross u_cross (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .ax        (s_vertex_a_x),
        .ay        (s_vertex_a_y),
        .az        (s_vertex_a_z),
        .bx        (s_vertex_b_x),
        .by        (s_vertex_b_y),
        .bz        (s_vertex_b_z),
        .cx        (s_vertex_c_x),
        .cy        (s_vertex_c_y),
        .cz        (s_vertex_c_z),
        .out_valid (sq_valid),
        .out_beat  (sq_beat)
    );

    tfn_root u_root (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_beat   (sq_beat),
        .out_valid (m_valid),
        .nx        (m_normal_x),
        .ny        (m_normal_y),
        .nz        (m_normal_z),
        .degen     (m_degenerate)
    );

`ifndef SYNTHESIS
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready does not follow output stall");
    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> m_normal_x == '0 && m_normal_z == '0
                                    && m_normal_y == MAX_VAL)
        else $error("degenerate beat without fallback normal");
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_normal_x != -FULL_VAL && m_normal_y != -FULL_VAL
                    && m_normal_z != -FULL_VAL)
        else $error("normal component outside saturation range");
`endif

endmodule
